>>> rtl/ztws_pkg.sv
`default_nettype none
package ztws_pkg;
    localparam int KIND_BITS  = 2;
    localparam int ZONE_BITS  = 4;
    localparam int TIME_BITS  = 32;
    localparam int CALLS_BITS = 16;
    localparam int FILL_BITS  = 7;
    localparam int CFG_BITS   = 5;
    localparam int REPORT_ZONES_MAX = 16;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_BEGIN = 2'd0,
        KIND_END   = 2'd1,
        KIND_SET   = 2'd2,
        KIND_TICK  = 2'd3
    } kind_t;

    localparam logic [TIME_BITS-1:0]  TIME_MAX  = '1;
    localparam logic [CALLS_BITS-1:0] CALLS_MAX = '1;
endpackage
`default_nettype wire

>>> rtl/ztws_ram.sv
`default_nettype none
module ztws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/ztws_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module ztws_div #(
    parameter int NUM_BITS = 38,
    parameter int DEN_BITS = 9
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [NUM_BITS-1:0] num,
    input  wire logic [DEN_BITS-1:0] den,
    output logic                     done,
    output logic      [NUM_BITS-1:0] quo
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] quo_reg, quo_next;
    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DEN_BITS:0]   trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[NUM_BITS-1]};
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_BITS'(NUM_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DEN_BITS'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_BITS-1:0];
                quo_next = {quo_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule
`default_nettype wire

>>> rtl/zone_timing_window_statistics.sv
`default_nettype none
// channel  | dir | tdata fields (low bit up)                         | tuser | tlast
// s_axis   | in  | zone[3:0], timestamp[51:4], set_time[83:52],       | kind  | -
//          |     | set_calls[99:84]                                   |       |
// m_axis   | out | report_zone, frame_time, window_average,           | -     | last_row
//          |     | least_time, greatest_time, frame_calls, samples_held|      |
// cfg      | in  | cfg_wdata = zones_in_use, written when cfg_we      |       |
// Begin/set/ignored: ST_WAIT. End: ST_END, ST_ACC (shared adder: difference, then sum).
// A frame tick walks every slot in turn: ring read, sum update,
// the one shared serial divider, then output.
// A report row waits in the output register; the walk stalls until it is taken.
// Reset zeroes per-zone registers, least_reg to TIME_MAX; ring memory is never cleared.
module zone_timing_window_statistics #(
    parameter int ZONE_SLOTS   = 16,
    parameter int WINDOW_DEPTH = 64,
    parameter int STAMP_BITS   = 48
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [103:0] s_axis_tdata,   // zone, timestamp, set_time, set_calls
    input  wire logic [1:0]   s_axis_tuser,   // kind
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [191:0]      m_axis_tdata,   // report_zone, frame_time, window_average,
                                              // least_time, greatest_time, frame_calls,
                                              // samples_held
    output logic              m_axis_tlast,   // last_row
    input  wire logic         cfg_we,
    input  wire logic [4:0]   cfg_wdata
);
    localparam int SLOT_BITS = (ZONE_SLOTS > 1) ? $clog2(ZONE_SLOTS) : 1;
    localparam int POS_BITS  = $clog2(WINDOW_DEPTH);
    localparam int FILLW     = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_BITS  = ztws_pkg::TIME_BITS + POS_BITS;
    localparam int DIFF_BITS = STAMP_BITS + 1;
    localparam int CNTW      = SLOT_BITS + 1;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b00000001,
        ST_END  = 8'b00000010,
        ST_ACC  = 8'b00000100,
        ST_RD   = 8'b00001000,
        ST_SUM  = 8'b00010000,
        ST_DIV  = 8'b00100000,
        ST_OUT  = 8'b01000000,
        ST_WAIT = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    logic [ztws_pkg::CFG_BITS-1:0]   zones_reg;
    logic [STAMP_BITS-1:0]           start_reg  [ZONE_SLOTS];
    logic [ztws_pkg::TIME_BITS-1:0]  total_reg  [ZONE_SLOTS];
    logic [ztws_pkg::CALLS_BITS-1:0] calls_reg  [ZONE_SLOTS];
    logic [SUM_BITS-1:0]             wsum_reg   [ZONE_SLOTS];
    logic [ztws_pkg::TIME_BITS-1:0]  least_reg  [ZONE_SLOTS];
    logic [ztws_pkg::TIME_BITS-1:0]  great_reg  [ZONE_SLOTS];
    logic [ZONE_SLOTS-1:0]           seen_reg;
    logic [POS_BITS-1:0]             pos_reg;
    logic [FILLW-1:0]                fill_reg;

    logic [ztws_pkg::ZONE_BITS-1:0]  zone_lat_reg;
    logic [STAMP_BITS-1:0]           stamp_lat_reg;
    logic [DIFF_BITS-1:0]            diff_reg;
    logic [SLOT_BITS-1:0]            slot_reg;
    logic [ztws_pkg::TIME_BITS-1:0]  tot_lat_reg;
    logic [ztws_pkg::CALLS_BITS-1:0] calls_lat_reg;
    logic                            full_reg;
    logic [FILLW-1:0]                nfill_reg;

    logic                   m_valid_reg;
    logic [191:0]           m_data_reg;
    logic                   m_last_reg;

    // input fields
    logic [ztws_pkg::ZONE_BITS-1:0]  in_zone;
    logic [47:0]                     in_stamp48;
    logic [STAMP_BITS-1:0]           in_stamp;
    logic [ztws_pkg::TIME_BITS-1:0]  in_set_time;
    logic [ztws_pkg::CALLS_BITS-1:0] in_set_calls;
    ztws_pkg::kind_t                 in_kind;

    assign in_zone      = s_axis_tdata[3:0];
    assign in_stamp48   = s_axis_tdata[51:4];
    assign in_set_time  = s_axis_tdata[83:52];
    assign in_set_calls = s_axis_tdata[99:84];
    assign in_kind      = ztws_pkg::kind_t'(s_axis_tuser);

    if (STAMP_BITS >= 48)
    begin : g_stamp_wide
        assign in_stamp = STAMP_BITS'(in_stamp48);
    end
    else
    begin : g_stamp_narrow
        assign in_stamp = in_stamp48[STAMP_BITS-1:0];
    end

    logic [CNTW-1:0] n_act;
    always_comb
    begin
        n_act = (zones_reg > 5'(ZONE_SLOTS)) ? CNTW'(ZONE_SLOTS) : CNTW'(zones_reg);
        if (n_act > CNTW'(ztws_pkg::REPORT_ZONES_MAX))
        begin
            n_act = CNTW'(ztws_pkg::REPORT_ZONES_MAX);
        end
    end

    logic in_use;
    assign in_use = ({1'b0, in_zone} < (ztws_pkg::ZONE_BITS + 1)'(n_act));

    logic [SLOT_BITS-1:0] zs;
    assign zs = SLOT_BITS'(zone_lat_reg);
    logic [SLOT_BITS-1:0] iz;
    assign iz = SLOT_BITS'(in_zone);

    logic accept;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;

    // ring memory
    logic                                  ram_we;
    logic [SLOT_BITS+POS_BITS-1:0]         ram_addr;
    logic [ztws_pkg::TIME_BITS-1:0]        ram_rdata;
    assign ram_addr = {slot_reg, pos_reg};

    ztws_ram #(
        .WIDTH(ztws_pkg::TIME_BITS),
        .DEPTH(1 << (SLOT_BITS + POS_BITS))
    ) u_ring (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_addr),
        .wdata(tot_lat_reg),
        .raddr(ram_addr),
        .rdata(ram_rdata)
    );

    // divider
    logic                div_start;
    logic                div_done;
    logic [SUM_BITS-1:0] div_quo;
    logic [SUM_BITS-1:0] sum_new;

    ztws_div #(
        .NUM_BITS(SUM_BITS),
        .DEN_BITS(FILLW)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (sum_new),
        .den  (nfill_reg),
        .done (div_done),
        .quo  (div_quo)
    );

    // shared adder
    logic [DIFF_BITS-1:0] add_a, add_b, add_y;
    assign add_y = add_a + add_b;

    logic [SUM_BITS-1:0] old_val;
    assign old_val = full_reg ? SUM_BITS'(ram_rdata) : '0;
    assign sum_new = wsum_reg[slot_reg] - old_val + SUM_BITS'(tot_lat_reg);

    always_comb
    begin
        add_a = '0;
        add_b = '0;
        unique case (state_reg)
            ST_END:
            begin
                add_a = {1'b0, stamp_lat_reg};
                add_b = ~{1'b0, start_reg[zs]} + 1'b1;
            end
            ST_ACC:
            begin
                add_a = DIFF_BITS'(total_reg[zs]);
                add_b = (diff_reg > DIFF_BITS'(ztws_pkg::TIME_MAX)) ?
                        DIFF_BITS'(ztws_pkg::TIME_MAX) : diff_reg;
            end
            default:
            begin
                add_a = '0;
                add_b = '0;
            end
        endcase
    end

    logic last_slot;
    assign last_slot = (slot_reg == SLOT_BITS'(ZONE_SLOTS - 1));

    always_comb
    begin
        state_next = state_reg;
        ram_we     = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_kind == ztws_pkg::KIND_TICK)
                    begin
                        state_next = ST_RD;
                    end
                    else if (in_kind == ztws_pkg::KIND_END && in_use)
                    begin
                        state_next = ST_END;
                    end
                    else
                    begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_END:  state_next = ST_ACC;
            ST_ACC:  state_next = ST_IDLE;
            ST_WAIT: state_next = ST_IDLE;
            ST_RD:   state_next = ST_SUM;
            ST_SUM:
            begin
                ram_we     = 1'b1;
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    state_next = last_slot ? ST_IDLE : ST_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    logic out_fire;
    assign out_fire = (state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready);
    logic report;
    assign report = ({1'b0, slot_reg} < n_act);

    logic [ztws_pkg::TIME_BITS-1:0] lo_new, hi_new;
    logic                           seen_new;
    always_comb
    begin
        lo_new   = least_reg[slot_reg];
        hi_new   = great_reg[slot_reg];
        seen_new = seen_reg[slot_reg];
        if (calls_lat_reg != '0)
        begin
            if (tot_lat_reg < lo_new) lo_new = tot_lat_reg;
            if (tot_lat_reg > hi_new) hi_new = tot_lat_reg;
            seen_new = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            zones_reg   <= 5'd10;
            pos_reg     <= '0;
            fill_reg    <= '0;
            seen_reg    <= '0;
            m_valid_reg <= 1'b0;
            slot_reg    <= '0;
            for (int i = 0; i < ZONE_SLOTS; i++)
            begin
                start_reg[i] <= '0;
                total_reg[i] <= '0;
                calls_reg[i] <= '0;
                wsum_reg[i]  <= '0;
                least_reg[i] <= ztws_pkg::TIME_MAX;
                great_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                zones_reg <= cfg_wdata;
            end
            if (out_fire)
            begin
                m_valid_reg <= report;
            end
            else if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (accept && in_kind != ztws_pkg::KIND_TICK && in_use)
            begin
                if (in_kind == ztws_pkg::KIND_BEGIN)
                begin
                    start_reg[iz] <= in_stamp;
                end
                else if (in_kind == ztws_pkg::KIND_SET)
                begin
                    total_reg[iz] <= in_set_time;
                    calls_reg[iz] <= in_set_calls;
                end
            end
            if (accept && in_kind == ztws_pkg::KIND_TICK)
            begin
                slot_reg <= '0;
            end
            if (state_reg == ST_ACC)
            begin
                total_reg[zs] <= add_y[DIFF_BITS-1:ztws_pkg::TIME_BITS] != '0 ?
                                 ztws_pkg::TIME_MAX : add_y[ztws_pkg::TIME_BITS-1:0];
                if (calls_reg[zs] != ztws_pkg::CALLS_MAX)
                begin
                    calls_reg[zs] <= calls_reg[zs] + 1'b1;
                end
            end
            if (state_reg == ST_SUM)
            begin
                wsum_reg[slot_reg]  <= sum_new;
                least_reg[slot_reg] <= lo_new;
                great_reg[slot_reg] <= hi_new;
                seen_reg[slot_reg]  <= seen_new;
                total_reg[slot_reg] <= '0;
                calls_reg[slot_reg] <= '0;
            end
            if (out_fire)
            begin
                if (last_slot)
                begin
                    pos_reg  <= (pos_reg == POS_BITS'(WINDOW_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
                    fill_reg <= nfill_reg;
                end
                else
                begin
                    slot_reg <= slot_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            zone_lat_reg  <= in_zone;
            stamp_lat_reg <= in_stamp;
            full_reg      <= (fill_reg >= FILLW'(WINDOW_DEPTH));
            nfill_reg     <= (fill_reg >= FILLW'(WINDOW_DEPTH)) ? FILLW'(WINDOW_DEPTH)
                                                                : fill_reg + 1'b1;
        end
        if (state_reg == ST_END)
        begin
            diff_reg <= add_y[DIFF_BITS-1] ? '0 : add_y;
        end
        if (state_reg == ST_RD)
        begin
            tot_lat_reg   <= total_reg[slot_reg];
            calls_lat_reg <= calls_reg[slot_reg];
        end
        if (out_fire && report)
        begin
            m_data_reg <= {
                37'd0,
                ztws_pkg::FILL_BITS'(nfill_reg),
                calls_lat_reg,
                seen_reg[slot_reg] ? great_reg[slot_reg] : 32'd0,
                seen_reg[slot_reg] ? least_reg[slot_reg] : 32'd0,
                div_quo[ztws_pkg::TIME_BITS-1:0],
                tot_lat_reg,
                ztws_pkg::ZONE_BITS'(slot_reg)
            };
            m_last_reg <= ({1'b0, slot_reg} + 1'b1 == n_act);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
endmodule
`default_nettype wire
